[rtl/fpa_pkg.sv]
package fpa_pkg;

    // operand format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // widths of the serial units
    localparam int DVD_BITS = WORD_BITS + FRAC_BITS;
    localparam int MAG_BITS = (2 * WORD_BITS > DVD_BITS) ? 2 * WORD_BITS : DVD_BITS;

    // saturation limits
    localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS - 1){1'b0}}};

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVF     = 2'd1,
        ST_DIVZERO = 2'd2
    } t_status;

    // completion of the serial adder
    typedef struct packed {
        logic                 done;
        logic                 ovf;
        logic [WORD_BITS-1:0] sum;
    } t_add_out;

    // completion of the multiplier or divider: unsigned magnitude
    typedef struct packed {
        logic                done;
        logic [MAG_BITS-1:0] mag;
    } t_mag_out;

endpackage

[rtl/fixed_point_four_function_alu.sv]
// Signed Q16.16 add, subtract, multiply and divide with saturation. Each beat
// carries an op code and two operands and yields one beat holding the result
// and a status (ok, overflow saturated, divide by zero). Operands pass
// through bit-serial units one bit per cycle: add and subtract in a serial
// full adder, multiply by shift-and-add, divide by a restoring divider over
// the dividend scaled by 2^16. Each item is loaded into its unit, shifted
// through it and then packed into the result; a zero divisor skips the
// serial units. No new item is taken until the last one is packed. Product
// and quotient truncate toward zero. The output register holds one finished
// result, and the next item is accepted while it waits to be taken.
module fixed_point_four_function_alu
    import fpa_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_op,
    input  logic signed [WORD_BITS-1:0] i_operand_a,
    input  logic signed [WORD_BITS-1:0] i_operand_b,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic [1:0]                  o_status
);

    logic                 w_accept;
    t_op                  w_op;
    logic [WORD_BITS-1:0] w_ma;
    logic [WORD_BITS-1:0] w_mb;
    logic                 w_zdiv;
    logic                 w_add_start;
    logic                 w_mul_start;
    logic                 w_div_start;
    t_add_out             w_add;
    t_mag_out             w_mul;
    t_mag_out             w_div;
    logic                 w_unit_done;
    logic                 w_fin;
    logic                 w_out_free;

    logic                 r_busy;
    logic                 r_pend;
    t_op                  r_op;
    logic                 r_neg;
    logic                 r_a_neg;
    logic                 r_zdiv;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_value;
    t_status              r_out_status;

    logic [MAG_BITS-1:0]  n_mag;
    logic [WORD_BITS-1:0] n_lo;
    logic                 n_ovf;
    logic [WORD_BITS-1:0] n_value;
    t_status              n_status;

    // input beat and operand magnitudes
    assign o_ready     = !r_busy && !r_pend;
    assign w_accept    = i_valid && o_ready;
    assign w_op        = t_op'(i_op);
    assign w_ma        = i_operand_a[WORD_BITS-1] ? (~i_operand_a + 1'b1) : i_operand_a;
    assign w_mb        = i_operand_b[WORD_BITS-1] ? (~i_operand_b + 1'b1) : i_operand_b;
    assign w_zdiv      = (w_op == OP_DIV) && (i_operand_b == '0);
    assign w_add_start = w_accept && ((w_op == OP_ADD) || (w_op == OP_SUB));
    assign w_mul_start = w_accept && (w_op == OP_MUL);
    assign w_div_start = w_accept && (w_op == OP_DIV) && !w_zdiv;

    // serial units
    fpa_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_add_start),
        .i_sub   (w_op == OP_SUB),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_res   (w_add)
    );

    fpa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_ma    (w_ma),
        .i_mb    (w_mb),
        .o_res   (w_mul)
    );

    fpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_ma    (w_ma),
        .i_mb    (w_mb),
        .o_res   (w_div)
    );

    assign w_unit_done = w_add.done || w_mul.done || w_div.done;
    assign w_fin       = w_unit_done || r_pend;
    assign w_out_free  = !r_out_valid || i_ready;

    // result packing: saturate and apply the sign
    always_comb begin
        n_mag    = (r_op == OP_MUL) ? w_mul.mag : w_div.mag;
        n_lo     = n_mag[WORD_BITS-1:0];
        n_ovf    = 1'b0;
        n_value  = '0;
        n_status = ST_OK;
        case (r_op)
            OP_ADD, OP_SUB: begin
                n_ovf   = w_add.ovf;
                n_value = w_add.ovf ? (r_a_neg ? MIN_NEG : MAX_POS) : w_add.sum;
            end
            OP_MUL, OP_DIV: begin
                n_ovf   = (|n_mag[MAG_BITS-1:WORD_BITS])
                          || (r_neg ? (n_lo > MIN_NEG) : (n_lo > MAX_POS));
                n_value = n_ovf ? (r_neg ? MIN_NEG : MAX_POS)
                                : (r_neg ? (~n_lo + 1'b1) : n_lo);
            end
            default: begin
                n_ovf   = 1'b0;
                n_value = '0;
            end
        endcase
        if (n_ovf) begin
            n_status = ST_OVF;
        end
        if (r_zdiv) begin
            n_value  = '0;
            n_status = ST_DIVZERO;
        end
    end

    // item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= !w_zdiv;
                r_pend <= w_zdiv;
            end else begin
                if (w_unit_done) begin
                    r_busy <= 1'b0;
                end
                if (w_fin) begin
                    r_pend <= !w_out_free;
                end
            end
            if (w_fin && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item attributes and output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= w_op;
            r_neg   <= i_operand_a[WORD_BITS-1] ^ i_operand_b[WORD_BITS-1];
            r_a_neg <= i_operand_a[WORD_BITS-1];
            r_zdiv  <= w_zdiv;
        end
        if (w_fin && w_out_free) begin
            r_out_value  <= n_value;
            r_out_status <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

`ifndef SYNTHESIS
    // at most one unit finishes at a time
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_add.done, w_mul.done, w_div.done}))
        else $error("more than one serial unit finished together");

    // a unit finishes only while an item is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_unit_done |-> r_busy)
        else $error("serial unit finished with no item in flight");

    // an accepted item is either working or waiting
    a_accept_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy || r_pend))
        else $error("accepted item lost");

    // divide by zero gives zero
    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_DIVZERO)) |-> (r_out_value == '0))
        else $error("divide by zero with nonzero result");

    // overflow gives a limit value
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_OVF))
        |-> ((r_out_value == MAX_POS) || (r_out_value == MIN_NEG)))
        else $error("overflow without saturated result");
`endif

endmodule

[rtl/fpa_add.sv]
module fpa_add
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_sub,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    output t_add_out             o_res
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_sum;
    logic                 r_carry;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_ovf;
    logic                 n_bit;
    logic                 n_carry;
    logic                 n_last;

    // one full adder, lsb first
    always_comb begin
        n_bit   = r_a[0] ^ r_b[0] ^ r_carry;
        n_carry = (r_a[0] & r_b[0]) | (r_a[0] & r_carry) | (r_b[0] & r_carry);
        n_last  = (r_cnt == CNT_BITS'(WORD_BITS - 1));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and sum shift registers; subtract adds the inverse plus one
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a     <= i_a;
            r_b     <= i_sub ? ~i_b : i_b;
            r_carry <= i_sub;
        end else if (r_busy) begin
            r_a     <= r_a >> 1;
            r_b     <= r_b >> 1;
            r_sum   <= {n_bit, r_sum[WORD_BITS-1:1]};
            r_carry <= n_carry;
            if (n_last) begin
                r_ovf <= r_carry ^ n_carry;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.sum  = r_sum;

endmodule

[rtl/fpa_mul.sv]
module fpa_mul
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_ma,
    input  logic [WORD_BITS-1:0] i_mb,
    output t_mag_out             o_res
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0]   r_mcand;
    logic [WORD_BITS-1:0]   r_acc;
    logic [WORD_BITS-1:0]   r_mpl;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [WORD_BITS:0]     n_sum;
    logic [2*WORD_BITS-1:0] w_prod;

    // add the multiplicand when the current multiplier bit is set
    always_comb begin
        n_sum = {1'b0, r_acc} + (r_mpl[0] ? {1'b0, r_mcand} : '0);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shifts right one bit per cycle into the multiplier register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_ma;
            r_mpl   <= i_mb;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_acc <= n_sum[WORD_BITS:1];
            r_mpl <= {n_sum[0], r_mpl[WORD_BITS-1:1]};
        end
    end

    // drop the fraction bits of the double-width product
    assign w_prod     = {r_acc, r_mpl};
    assign o_res.done = r_done;
    assign o_res.mag  = MAG_BITS'(w_prod >> FRAC_BITS);

endmodule

[rtl/fpa_div.sv]
module fpa_div
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_ma,
    input  logic [WORD_BITS-1:0] i_mb,
    output t_mag_out             o_res
);

    localparam int CNT_BITS = $clog2(DVD_BITS);

    logic [DVD_BITS-1:0]  r_dvd;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_dvs;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [WORD_BITS:0]   n_shift;
    logic [WORD_BITS:0]   n_diff;
    logic                 n_ge;

    // restoring step: bring in the next dividend bit and trial subtract
    always_comb begin
        n_shift = {r_rem, r_dvd[DVD_BITS-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_ge    = (n_shift >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DVD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // scaled dividend shifts out at the top, quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DVD_BITS'(i_ma) << FRAC_BITS;
            r_dvs <= i_mb;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_BITS-2:0], n_ge};
            r_rem <= n_ge ? n_diff[WORD_BITS-1:0] : n_shift[WORD_BITS-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.mag  = MAG_BITS'(r_dvd);

endmodule
